### rtl/core/segment_crossing_test_assert.svh
// Assertion macros used by the segment crossing test checker
`ifndef SEGMENT_CROSSING_TEST_ASSERT_SVH
`define SEGMENT_CROSSING_TEST_ASSERT_SVH

// same-cycle implication, silent while reset is asserted
`define SCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sct assertion failed");

// next-cycle implication, silent while reset is asserted
`define SCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sct assertion failed");

`endif

### rtl/core/sct_pkg.sv
// Types, constants and helper functions for the segment crossing test
package sct_pkg;

  localparam int unsigned NumTests    = 4;
  localparam int unsigned TestStart   = 0;
  localparam int unsigned TestEnd     = 1;
  localparam int unsigned TestLineOrg = 2;
  localparam int unsigned TestLineEnd = 3;

  typedef struct packed {
    logic [31:0] line_x;
    logic [31:0] line_y;
    logic [31:0] line_dx;
    logic [31:0] line_dy;
    logic [31:0] seg_x;
    logic [31:0] seg_y;
    logic [31:0] seg_dx;
    logic [31:0] seg_dy;
  } sct_in_t;

  typedef struct packed {
    logic crossed;
    logic start_side;
  } sct_out_t;

  typedef struct packed {
    logic precise_mode;
  } sct_cfg_t;

  typedef struct packed {
    sct_in_t     geo;
    logic [31:0] seg_ex;
    logic [31:0] seg_ey;
    logic [31:0] line_ex;
    logic [31:0] line_ey;
  } sct_geom_t;

  typedef struct packed {
    logic [32:0] m1a;
    logic [31:0] m1b;
    logic [32:0] m2a;
    logic [31:0] m2b;
    logic        fixed;
    logic        fixed_val;
    logic        trunc;
  } sct_ops_t;

  typedef struct packed {
    logic [64:0] p1;
    logic [64:0] p2;
    logic        fixed;
    logic        fixed_val;
    logic        trunc;
  } sct_prod_t;

  function automatic logic zero_side(input logic px_le, input logic py_le,
                                     input logic [31:0] dx, input logic [31:0] dy);
    logic r;
    if (dx == '0) begin
      r = px_le ? (!dy[31] && (dy != '0)) : dy[31];
    end else begin
      r = py_le ? dx[31] : (!dx[31] && (dx != '0));
    end
    return r;
  endfunction

  function automatic logic [64:0] smul(input logic [32:0] a, input logic [31:0] b);
    logic [64:0] ea;
    logic [64:0] eb;
    ea = {{32{a[32]}}, a};
    eb = {{33{b[31]}}, b};
    return ea * eb;
  endfunction

endpackage

### rtl/core/sct_stream_if.sv
// Valid/ready channel carrying one payload per transaction
interface sct_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/segment_crossing_test.sv
// Segment crossing test top level: four-stage pipeline of side tests
//
//   channel | dir | payload
//   in_i    | in  | line_x/y, line_dx/dy, seg_x/y, seg_dx/dy (32 bit each)
//   cfg_i   | in  | precise_mode (1 bit), always ready
//   out_o   | out | crossed, start_side
//
// One transaction per cycle while the output is not stalled; the stages are the endpoint adders,
// operand select, the eight 33x32 multipliers and the final compare stage.
// Reset clears the stage valid bits and precise_mode.
// Each stage holds while its successor is full and stalled; bubbles close up,
// so input is taken while a result waits as long as any stage is empty.
module segment_crossing_test (
  input  logic         clk_i,
  input  logic         rst_ni,
  sct_stream_if.sink   in_i,
  sct_stream_if.sink   cfg_i,
  sct_stream_if.source out_o
);

  logic mode_q;

  logic                 v1_q, v2_q, v3_q, vo_q;
  logic                 en0, en1, en2, en3;
  sct_pkg::sct_geom_t   s1_d, s1_q;
  sct_pkg::sct_ops_t    s2_d [sct_pkg::NumTests];
  sct_pkg::sct_ops_t    s2_q [sct_pkg::NumTests];
  sct_pkg::sct_prod_t   s3_d [sct_pkg::NumTests];
  sct_pkg::sct_prod_t   s3_q [sct_pkg::NumTests];
  sct_pkg::sct_out_t    o_d, o_q;

  assign en3 = !vo_q || out_o.ready;
  assign en2 = !v3_q || en3;
  assign en1 = !v2_q || en2;
  assign en0 = !v1_q || en1;

  assign in_i.ready  = en0;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid   = vo_q;
  assign out_o.payload = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.payload.precise_mode;
    end
  end

  // endpoint sums
  always_comb begin
    s1_d.geo     = in_i.payload;
    s1_d.seg_ex  = in_i.payload.seg_x + in_i.payload.seg_dx;
    s1_d.seg_ey  = in_i.payload.seg_y + in_i.payload.seg_dy;
    s1_d.line_ex = in_i.payload.line_x + in_i.payload.line_dx;
    s1_d.line_ey = in_i.payload.line_y + in_i.payload.line_dy;
  end

  // differences, zero-delta rules, sign shortcut and operand select
  always_comb begin
    logic [31:0] px [sct_pkg::NumTests];
    logic [31:0] py [sct_pkg::NumTests];
    logic [32:0] rx, ry;
    logic [31:0] wx, wy;
    logic        lz, dz, sc;

    px[sct_pkg::TestStart]   = s1_q.geo.seg_x;
    py[sct_pkg::TestStart]   = s1_q.geo.seg_y;
    px[sct_pkg::TestEnd]     = s1_q.seg_ex;
    py[sct_pkg::TestEnd]     = s1_q.seg_ey;
    px[sct_pkg::TestLineOrg] = s1_q.geo.line_x;
    py[sct_pkg::TestLineOrg] = s1_q.geo.line_y;
    px[sct_pkg::TestLineEnd] = s1_q.line_ex;
    py[sct_pkg::TestLineEnd] = s1_q.line_ey;

    lz = (s1_q.geo.line_dx == '0) || (s1_q.geo.line_dy == '0);
    dz = (s1_q.geo.seg_dx == '0) || (s1_q.geo.seg_dy == '0);

    for (int k = 0; k < 2; k++) begin
      rx = {px[k][31], px[k]} - {s1_q.geo.line_x[31], s1_q.geo.line_x};
      ry = {py[k][31], py[k]} - {s1_q.geo.line_y[31], s1_q.geo.line_y};
      s2_d[k].fixed     = lz;
      s2_d[k].fixed_val = sct_pkg::zero_side(rx[32] || (rx == '0), ry[32] || (ry == '0),
                                             s1_q.geo.line_dx, s1_q.geo.line_dy);
      if (mode_q) begin
        s2_d[k].m1a   = ry;
        s2_d[k].m1b   = s1_q.geo.line_dx;
        s2_d[k].m2a   = rx;
        s2_d[k].m2b   = s1_q.geo.line_dy;
        s2_d[k].trunc = 1'b0;
      end else begin
        s2_d[k].m1a   = {ry[31], ry[31:0]};
        s2_d[k].m1b   = {{16{s1_q.geo.line_dx[31]}}, s1_q.geo.line_dx[31:16]};
        s2_d[k].m2a   = {rx[31], rx[31:0]};
        s2_d[k].m2b   = {{16{s1_q.geo.line_dy[31]}}, s1_q.geo.line_dy[31:16]};
        s2_d[k].trunc = 1'b1;
      end
    end

    for (int k = 2; k < 4; k++) begin
      wx = px[k] - s1_q.geo.seg_x;
      wy = py[k] - s1_q.geo.seg_y;
      sc = s1_q.geo.seg_dy[31] ^ s1_q.geo.seg_dx[31] ^ wx[31] ^ wy[31];
      s2_d[k].fixed = dz || sc;
      if (dz) begin
        s2_d[k].fixed_val = sct_pkg::zero_side(
          $signed(px[k]) <= $signed(s1_q.geo.seg_x),
          $signed(py[k]) <= $signed(s1_q.geo.seg_y),
          s1_q.geo.seg_dx, s1_q.geo.seg_dy);
      end else begin
        s2_d[k].fixed_val = s1_q.geo.seg_dy[31] != wx[31];
      end
      s2_d[k].m1a   = {wy[31], wy};
      s2_d[k].m1b   = s1_q.geo.seg_dx;
      s2_d[k].m2a   = {wx[31], wx};
      s2_d[k].m2b   = s1_q.geo.seg_dy;
      s2_d[k].trunc = 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < sct_pkg::NumTests; k++) begin
      s3_d[k].p1        = sct_pkg::smul(s2_q[k].m1a, s2_q[k].m1b);
      s3_d[k].p2        = sct_pkg::smul(s2_q[k].m2a, s2_q[k].m2b);
      s3_d[k].fixed     = s2_q[k].fixed;
      s3_d[k].fixed_val = s2_q[k].fixed_val;
      s3_d[k].trunc     = s2_q[k].trunc;
    end
  end

  always_comb begin
    logic [sct_pkg::NumTests-1:0] side;
    for (int k = 0; k < sct_pkg::NumTests; k++) begin
      if (s3_q[k].fixed) begin
        side[k] = s3_q[k].fixed_val;
      end else if (s3_q[k].trunc) begin
        side[k] = $signed(s3_q[k].p1[47:16]) >= $signed(s3_q[k].p2[47:16]);
      end else begin
        side[k] = $signed(s3_q[k].p1) >= $signed(s3_q[k].p2);
      end
    end
    o_d.crossed    = (side[sct_pkg::TestStart] ^ side[sct_pkg::TestEnd]) &&
                     (side[sct_pkg::TestLineOrg] ^ side[sct_pkg::TestLineEnd]);
    o_d.start_side = o_d.crossed && side[sct_pkg::TestStart];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en0) v1_q <= in_i.valid;
      if (en1) v2_q <= v1_q;
      if (en2) v3_q <= v2_q;
      if (en3) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) s1_q <= s1_d;
    if (en1) s2_q <= s2_d;
    if (en2) s3_q <= s3_d;
    if (en3) o_q  <= o_d;
  end

endmodule

### rtl/core/sct_checker.sv
// Port-level checker for the segment crossing test and its bind
`include "segment_crossing_test_assert.svh"

module sct_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_crossed_i,
  input logic out_start_side_i
);

  `SCT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  `SCT_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_crossed_i) && $stable(out_start_side_i))

  `SCT_ASSERT_NOW(a_side_needs_cross, clk_i, rst_ni, out_valid_i && out_start_side_i, out_crossed_i)

  `SCT_ASSERT_NOW(a_stall_only_when_full, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i)

endmodule

bind segment_crossing_test sct_checker u_sct_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_crossed_i    (out_o.payload.crossed),
  .out_start_side_i (out_o.payload.start_side)
);
